// ===== rtl/core/dmc_pkg.sv =====
package dmc_pkg;

    localparam int OFFSET_BITS = 2;
    localparam int INDEX_BITS  = 4;
    localparam int ADDR_BITS   = 14;
    localparam int TAG_BITS    = ADDR_BITS - OFFSET_BITS - INDEX_BITS;
    localparam int ROW_BITS    = ADDR_BITS - OFFSET_BITS;
    localparam int LINE_BYTES  = 1 << OFFSET_BITS;
    localparam int SET_COUNT   = 1 << INDEX_BITS;
    localparam int ROW_COUNT   = 1 << ROW_BITS;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef logic [LINE_BYTES-1:0][7:0] t_line_data;

    typedef struct packed {
        logic                 mode;
        logic [ADDR_BITS-1:0] addr;
        logic [7:0]           wdata;
    } t_in_word;

    typedef struct packed {
        logic [7:0] rdata;
        logic       hit;
    } t_out_word;

    typedef struct packed {
        logic                   rd;
        logic                   wr;
        logic [ROW_BITS-1:0]    row;
        logic [OFFSET_BITS-1:0] lane;
        logic [7:0]             wdata;
    } t_mem_req;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        t_line_data          data;
    } t_line;

    typedef struct packed {
        logic                  rd;
        logic                  wr;
        logic [INDEX_BITS-1:0] set;
        t_line                 wline;
    } t_line_req;

endpackage

// ===== rtl/core/direct_mapped_cache_byte_read.sv =====
// Direct-mapped read cache of 16 sets with 4-byte lines in front of a
// 16 KiB byte memory. Words arrive on the input channel (valid/ready) and
// carry mode, address and write data. A write word stores one byte in the
// memory and produces no result; the cache is left untouched, so a later
// hit may return stale data. A read word produces one result word (rdata,
// hit) on the output channel.
// A read word first reads the set from the line RAM and the aligned row
// from the word-wide memory; in the compare state the block then compares
// the tag, loads the result register and, on a miss, writes the row and
// tag into the line RAM. No new word is taken until a read's result is
// loaded; writes are taken one per cycle while the block is idle.
// After reset the memory is swept to 0xFF one 4-byte row per cycle over
// all 4096 rows; ready stays low during the sweep and all sets are
// invalid. If the receiver stalls, the result waits in the output register;
// writes are still taken, and a further read waits in its compare state
// until the result register is free.
module direct_mapped_cache_byte_read (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dmc_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dmc_pkg::t_out_word o_out_word
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOOK = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    logic                            r_valid [dmc_pkg::SET_COUNT];
    logic [dmc_pkg::ADDR_BITS-1:0]   r_addr;
    logic                            r_out_valid;
    logic                            n_out_valid;
    dmc_pkg::t_out_word              r_out_word;
    dmc_pkg::t_out_word              n_out_word;

    dmc_pkg::t_mem_req               mem_req;
    dmc_pkg::t_line_data             mem_rdata;
    logic                            clearing;
    dmc_pkg::t_line_req              line_req;
    dmc_pkg::t_line                  line_rd;

    logic                            accept;
    logic                            finish;
    logic                            hit;
    logic [dmc_pkg::OFFSET_BITS-1:0] offset;
    logic [dmc_pkg::INDEX_BITS-1:0]  set_idx;
    logic [dmc_pkg::TAG_BITS-1:0]    tag;

    assign o_in_ready = (r_state == S_IDLE) && !clearing;
    assign accept     = i_in_valid && o_in_ready;

    assign offset  = r_addr[dmc_pkg::OFFSET_BITS-1:0];
    assign set_idx = r_addr[dmc_pkg::OFFSET_BITS +: dmc_pkg::INDEX_BITS];
    assign tag     = r_addr[dmc_pkg::ADDR_BITS-1 -: dmc_pkg::TAG_BITS];
    assign hit     = r_valid[set_idx] && (line_rd.tag == tag);
    assign finish  = (r_state == S_LOOK) && (!r_out_valid || i_out_ready);

    always_comb begin
        mem_req.rd    = accept && (i_in_word.mode == dmc_pkg::MODE_READ);
        mem_req.wr    = accept && (i_in_word.mode == dmc_pkg::MODE_WRITE);
        mem_req.row   = i_in_word.addr[dmc_pkg::ADDR_BITS-1:dmc_pkg::OFFSET_BITS];
        mem_req.lane  = i_in_word.addr[dmc_pkg::OFFSET_BITS-1:0];
        mem_req.wdata = i_in_word.wdata;

        line_req.rd         = mem_req.rd;
        line_req.wr         = finish && !hit;
        line_req.set        = mem_req.rd
            ? i_in_word.addr[dmc_pkg::OFFSET_BITS +: dmc_pkg::INDEX_BITS] : set_idx;
        line_req.wline.tag  = tag;
        line_req.wline.data = mem_rdata;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;
        unique case (r_state)
            S_IDLE: begin
                if (mem_req.rd) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (finish) begin
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_word.hit   = hit;
                    n_out_word.rdata = hit ? line_rd.data[offset] : mem_rdata[offset];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < dmc_pkg::SET_COUNT; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (line_req.wr) begin
                r_valid[set_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
        if (mem_req.rd) begin
            r_addr <= i_in_word.addr;
        end
    end

    dmc_phys_mem u_phys_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (mem_req),
        .o_rdata    (mem_rdata),
        .o_clearing (clearing)
    );

    dmc_line_ram u_line_ram (
        .i_clk   (i_clk),
        .i_req   (line_req),
        .o_rline (line_rd)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== rtl/core/dmc_phys_mem.sv =====
module dmc_phys_mem (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dmc_pkg::t_mem_req     i_req,
    output dmc_pkg::t_line_data   o_rdata,
    output logic                  o_clearing
);

    dmc_pkg::t_line_data r_mem [dmc_pkg::ROW_COUNT];
    dmc_pkg::t_line_data r_rdata;
    logic [dmc_pkg::ROW_BITS-1:0] r_clr_row;
    logic [dmc_pkg::ROW_BITS-1:0] n_clr_row;
    logic                         r_clearing;
    logic                         n_clearing;

    always_comb begin
        n_clr_row  = r_clr_row;
        n_clearing = r_clearing;
        if (r_clearing) begin
            n_clr_row = r_clr_row + 1'b1;
            if (r_clr_row == {dmc_pkg::ROW_BITS{1'b1}}) begin
                n_clearing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_row  <= '0;
            r_clearing <= 1'b1;
        end else begin
            r_clr_row  <= n_clr_row;
            r_clearing <= n_clearing;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_row] <= '1;
        end else if (i_req.wr) begin
            r_mem[i_req.row][i_req.lane] <= i_req.wdata;
        end
        if (i_req.rd) begin
            r_rdata <= r_mem[i_req.row];
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clearing;

endmodule

// ===== rtl/core/dmc_line_ram.sv =====
module dmc_line_ram (
    input  logic               i_clk,
    input  dmc_pkg::t_line_req i_req,
    output dmc_pkg::t_line     o_rline
);

    dmc_pkg::t_line r_ram [dmc_pkg::SET_COUNT];
    dmc_pkg::t_line r_rline;

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_ram[i_req.set] <= i_req.wline;
        end
        if (i_req.rd) begin
            r_rline <= r_ram[i_req.set];
        end
    end

    assign o_rline = r_rline;

endmodule

// ===== rtl/core/dmc_checker.sv =====
module dmc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input dmc_pkg::t_in_word  i_in_word,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input dmc_pkg::t_out_word o_out_word
);

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("block not quiet after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word changed");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_word.mode == dmc_pkg::MODE_READ) |=> !o_in_ready)
        else $error("read word did not occupy the block");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_word.mode == dmc_pkg::MODE_WRITE) |=> !$rose(o_out_valid))
        else $error("write word produced a result");

    a_result_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("block not ready when result appeared");

endmodule

bind direct_mapped_cache_byte_read dmc_checker u_dmc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

// ===== tb/direct_mapped_cache_byte_read_tb.sv =====
`timescale 1ns / 1ps

module direct_mapped_cache_byte_read_tb;

    localparam int RANDOM_WORDS = 1280;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_TOGGLE} t_rx_style;

    typedef struct packed {
        logic [dmc_pkg::ADDR_BITS-1:0] addr;
        dmc_pkg::t_out_word            word;
    } t_read_expect;

    typedef struct {
        dmc_pkg::t_in_word  word;
        bit                 typed;
        dmc_pkg::t_out_word want;
    } t_step;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    dmc_pkg::t_in_word  in_word = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    dmc_pkg::t_out_word out_word;

    logic [7:0]                   shadow_mem [dmc_pkg::ROW_COUNT*dmc_pkg::LINE_BYTES];
    logic [7:0]                   shadow_line [dmc_pkg::SET_COUNT*dmc_pkg::LINE_BYTES];
    logic [dmc_pkg::TAG_BITS-1:0] shadow_tag [dmc_pkg::SET_COUNT];
    logic                         shadow_valid [dmc_pkg::SET_COUNT];

    t_read_expect pending_reads[$];
    t_step        directed_steps[$];
    t_read_expect head_read;
    int           mismatches = 0;
    int           idle_cycles = 0;
    int           burst_left = 0;
    t_rx_style    rx_style = RX_OPEN;
    int           rx_phase = 0;

    direct_mapped_cache_byte_read dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic dmc_pkg::t_out_word predict_read(
        input logic [dmc_pkg::ADDR_BITS-1:0] a);
        logic [dmc_pkg::OFFSET_BITS-1:0] offset;
        logic [dmc_pkg::INDEX_BITS-1:0]  set_idx;
        logic [dmc_pkg::TAG_BITS-1:0]    tag;
        logic [dmc_pkg::OFFSET_BITS-1:0] lane;
        dmc_pkg::t_out_word              res;
        offset  = a[dmc_pkg::OFFSET_BITS-1:0];
        set_idx = a[dmc_pkg::OFFSET_BITS +: dmc_pkg::INDEX_BITS];
        tag     = a[dmc_pkg::ADDR_BITS-1 -: dmc_pkg::TAG_BITS];
        if (shadow_valid[set_idx] && shadow_tag[set_idx] == tag) begin
            res.rdata = shadow_line[{set_idx, offset}];
            res.hit   = 1'b1;
        end else begin
            for (int k = 0; k < dmc_pkg::LINE_BYTES; k++) begin
                lane = dmc_pkg::OFFSET_BITS'(k);
                shadow_line[{set_idx, lane}] =
                    shadow_mem[{a[dmc_pkg::ADDR_BITS-1:dmc_pkg::OFFSET_BITS], lane}];
            end
            shadow_tag[set_idx]   = tag;
            shadow_valid[set_idx] = 1'b1;
            res.rdata = shadow_mem[a];
            res.hit   = 1'b0;
        end
        return res;
    endfunction

    function automatic void add_step(input logic mode, input int addr, input int wdata,
                                     input bit typed, input int rdata, input bit hit);
        t_step s;
        s.word.mode  = mode;
        s.word.addr  = addr[dmc_pkg::ADDR_BITS-1:0];
        s.word.wdata = wdata[7:0];
        s.typed      = typed;
        s.want.rdata = rdata[7:0];
        s.want.hit   = hit;
        directed_steps.push_back(s);
    endfunction

    task automatic send_word(input t_step s);
        logic               took;
        int                 gap;
        t_read_expect       e;
        dmc_pkg::t_out_word guess;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_word  <= s.word;
        do begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end while (!took);
        if (s.word.mode == dmc_pkg::MODE_WRITE) begin
            shadow_mem[s.word.addr] = s.word.wdata;
        end else begin
            guess  = predict_read(s.word.addr);
            e.addr = s.word.addr;
            e.word = s.typed ? s.want : guess;
            pending_reads.push_back(e);
        end
    endtask

    always @(posedge clk) begin
        if (rx_phase == 0) begin
            rx_style <= t_rx_style'($urandom_range(0, 3));
            rx_phase <= $urandom_range(16, 200);
        end else begin
            rx_phase <= rx_phase - 1;
        end
        case (rx_style)
            RX_OPEN:   out_ready <= 1'b1;
            RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
            default:   out_ready <= ~out_ready;
        endcase
    end

    always @(negedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_reads.size() == 0) begin
                report_mismatch($sformatf("unexpected word rdata %02h hit %0b",
                                          out_word.rdata, out_word.hit));
            end else begin
                head_read = pending_reads.pop_front();
                if (out_word.rdata !== head_read.word.rdata) begin
                    report_mismatch($sformatf("addr %04h rdata %02h, want %02h", head_read.addr,
                                              out_word.rdata, head_read.word.rdata));
                end
                if (out_word.hit !== head_read.word.hit) begin
                    report_mismatch($sformatf("addr %04h hit %0b, want %0b", head_read.addr,
                                              out_word.hit, head_read.word.hit));
                end
            end
        end
    end

    always @(negedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("** direct_mapped_cache_byte_read: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        t_step                        s;
        logic [dmc_pkg::TAG_BITS-1:0] tag;
        foreach (shadow_mem[i]) begin
            shadow_mem[i] = 8'hFF;
        end
        foreach (shadow_line[i]) begin
            shadow_line[i] = 8'h00;
        end
        foreach (shadow_tag[i]) begin
            shadow_tag[i]   = '0;
            shadow_valid[i] = 1'b0;
        end

        // A write never touches the cache, so reads of a cached line return stale bytes
        // until an eviction forces a refill.
        add_step(dmc_pkg::MODE_READ,  16'h0000, 8'h00, 1'b1, 8'hFF, 1'b0);
        add_step(dmc_pkg::MODE_READ,  16'h0003, 8'hFF, 1'b1, 8'hFF, 1'b1);
        add_step(dmc_pkg::MODE_WRITE, 16'h0000, 8'h00, 1'b0, 0, 1'b0);
        add_step(dmc_pkg::MODE_READ,  16'h0000, 8'h00, 1'b1, 8'hFF, 1'b1);
        add_step(dmc_pkg::MODE_READ,  16'h3FFF, 8'h00, 1'b1, 8'hFF, 1'b0);
        add_step(dmc_pkg::MODE_READ,  16'h0040, 8'h00, 1'b1, 8'hFF, 1'b0);
        add_step(dmc_pkg::MODE_READ,  16'h0000, 8'h00, 1'b1, 8'h00, 1'b0);
        add_step(dmc_pkg::MODE_WRITE, 16'h3FFE, 8'hA5, 1'b0, 0, 1'b0);
        add_step(dmc_pkg::MODE_WRITE, 16'h3FFF, 8'hFF, 1'b0, 0, 1'b0);
        add_step(dmc_pkg::MODE_READ,  16'h3FFE, 8'h00, 1'b1, 8'hFF, 1'b1);
        add_step(dmc_pkg::MODE_WRITE, 16'h3FC2, 8'h3C, 1'b0, 0, 1'b0);
        add_step(dmc_pkg::MODE_READ,  16'h3FC2, 8'h00, 1'b1, 8'h3C, 1'b0);
        add_step(dmc_pkg::MODE_READ,  16'h3FC3, 8'h00, 1'b1, 8'hFF, 1'b1);
        add_step(dmc_pkg::MODE_READ,  16'h3FFC, 8'h00, 1'b1, 8'hFF, 1'b1);
        add_step(dmc_pkg::MODE_READ,  16'h0FFC, 8'h00, 1'b1, 8'hFF, 1'b0);
        add_step(dmc_pkg::MODE_READ,  16'h3FFE, 8'h00, 1'b1, 8'hA5, 1'b0);
        add_step(dmc_pkg::MODE_WRITE, 16'h1235, 8'h81, 1'b0, 0, 1'b0);
        add_step(dmc_pkg::MODE_READ,  16'h1235, 8'h00, 1'b1, 8'h81, 1'b0);
        add_step(dmc_pkg::MODE_READ,  16'h1234, 8'h00, 1'b0, 0, 1'b0);
        add_step(dmc_pkg::MODE_WRITE, 16'h2AAA, 8'h55, 1'b0, 0, 1'b0);
        add_step(dmc_pkg::MODE_READ,  16'h2AAA, 8'h00, 1'b0, 0, 1'b0);
        add_step(dmc_pkg::MODE_READ,  16'h1555, 8'h00, 1'b0, 0, 1'b0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i]) begin
            send_word(directed_steps[i]);
        end

        // Most tags come from a small pool so that lines are reused, evicted and go stale.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            tag = ($urandom_range(0, 9) < 7) ? dmc_pkg::TAG_BITS'($urandom_range(0, 3))
                                             : dmc_pkg::TAG_BITS'($urandom);
            s.word.mode  = ($urandom_range(0, 99) < 35) ? dmc_pkg::MODE_WRITE
                                                        : dmc_pkg::MODE_READ;
            s.word.addr  = {tag, dmc_pkg::INDEX_BITS'($urandom),
                            dmc_pkg::OFFSET_BITS'($urandom)};
            s.word.wdata = 8'($urandom);
            s.typed      = 1'b0;
            s.want       = '0;
            send_word(s);
        end
        in_valid <= 1'b0;

        while (pending_reads.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("** direct_mapped_cache_byte_read: PASSED **");
        end else begin
            $display("** direct_mapped_cache_byte_read: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/dmc_pkg.sv
rtl/core/dmc_phys_mem.sv
rtl/core/dmc_line_ram.sv
rtl/core/direct_mapped_cache_byte_read.sv
rtl/core/dmc_checker.sv
tb/direct_mapped_cache_byte_read_tb.sv
